// ===== src/dqls_pkg.sv =====
// Shared constants, types and address helper for the deque with linear search.
package dqls_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_SEARCH    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic             done;
    status_e          status;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] occupancy;
  } res_t;

  function automatic logic [IDX_W-1:0] slot_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] k);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(k);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== src/dqls_store.sv =====
// Ring store: one write port and one registered read port.
module dqls_store import dqls_pkg::*; (
  input  logic              clk_i,
  input  mem_req_t          mem_req_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[mem_req_i.raddr];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/dqls_ctrl.sv =====
// Sequencer: front/count bookkeeping, search walk and shared compare unit.
module dqls_ctrl import dqls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [2:0]        operation_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [DATA_W-1:0] rd_data_i,
  output mem_req_t          mem_req_o,
  output logic              busy_o,
  output res_t              res_o
);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  front_q;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  issue_k_q;
  logic [IDX_W-1:0]  cmp_k_q;
  logic              cmp_vld_q;
  logic [DATA_W-1:0] key_q;
  res_t              res_q;

  logic              accept;
  logic              full;
  logic              empty;
  logic [IDX_W-1:0]  front_dec;
  logic [CNT_W-1:0]  last_k;
  logic              hit;

  assign accept    = start_i && (state_q == S_IDLE);
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
  assign last_k    = count_q - 1'b1;
  assign hit       = (rd_data_i == key_q);

  always_comb begin
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = slot_add(front_q, count_q);
    mem_req_o.wdata = value_i;
    mem_req_o.raddr = slot_add(front_q, CNT_W'(issue_k_q));
    if (accept && !full) begin
      case (op_e'(operation_i))
        OP_INS_FRONT: begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = front_dec;
        end
        OP_INS_BACK: begin
          mem_req_o.we = 1'b1;
        end
        default: begin
          mem_req_o.we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      issue_k_q <= '0;
      cmp_k_q   <= '0;
      cmp_vld_q <= 1'b0;
      key_q     <= '0;
      res_q     <= '0;
    end else begin
      res_q.done <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            res_q.done     <= 1'b1;
            res_q.status   <= ST_OK;
            res_q.position <= '0;
            res_q.occupancy <= count_q;
            case (op_e'(operation_i))
              OP_INS_FRONT: begin
                if (full) begin
                  res_q.status <= ST_FULL;
                end else begin
                  front_q         <= front_dec;
                  count_q         <= count_q + 1'b1;
                  res_q.occupancy <= count_q + 1'b1;
                end
              end
              OP_INS_BACK: begin
                if (full) begin
                  res_q.status <= ST_FULL;
                end else begin
                  count_q         <= count_q + 1'b1;
                  res_q.occupancy <= count_q + 1'b1;
                end
              end
              OP_REM_FRONT: begin
                if (empty) begin
                  res_q.status <= ST_EMPTY;
                end else begin
                  front_q         <= slot_add(front_q, CNT_W'(1));
                  count_q         <= last_k;
                  res_q.occupancy <= last_k;
                end
              end
              OP_REM_BACK: begin
                if (empty) begin
                  res_q.status <= ST_EMPTY;
                end else begin
                  count_q         <= last_k;
                  res_q.occupancy <= last_k;
                end
              end
              OP_SEARCH: begin
                key_q     <= value_i;
                issue_k_q <= '0;
                cmp_vld_q <= 1'b0;
                if (empty) begin
                  res_q.status <= ST_NOTFOUND;
                end else begin
                  res_q.done <= 1'b0;
                  state_q    <= S_SEARCH;
                end
              end
              default: begin
                res_q.status <= ST_OK;
              end
            endcase
          end
        end
        S_SEARCH: begin
          cmp_vld_q <= 1'b1;
          cmp_k_q   <= issue_k_q;
          if (CNT_W'(issue_k_q) != last_k) begin
            issue_k_q <= issue_k_q + 1'b1;
          end
          if (cmp_vld_q) begin
            if (hit) begin
              res_q.done      <= 1'b1;
              res_q.status    <= ST_OK;
              res_q.position  <= CNT_W'(cmp_k_q) + 1'b1;
              res_q.occupancy <= count_q;
              cmp_vld_q       <= 1'b0;
              state_q         <= S_IDLE;
            end else if (CNT_W'(cmp_k_q) == last_k) begin
              res_q.done      <= 1'b1;
              res_q.status    <= ST_NOTFOUND;
              res_q.position  <= '0;
              res_q.occupancy <= count_q;
              cmp_vld_q       <= 1'b0;
              state_q         <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_search_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> !mem_req_o.we)
    else $error("write during search");

  a_cmp_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == S_SEARCH))
    else $error("compare valid outside search");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_q.done && res_q.position != '0) |->
      (res_q.status == ST_OK && res_q.position <= res_q.occupancy))
    else $error("position out of range");

  a_search_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |=> $stable(count_q) && $stable(front_q))
    else $error("pointers changed during search");
`endif

endmodule

// ===== src/deque_with_linear_search_top.sv =====
// Bounded deque of signed 32-bit values with front-to-back linear search.
// Inserts, removals and undefined codes need no busy phase: done_o pulses the
// cycle after the accepting edge and busy_o stays low, so a new item may be
// started every cycle. A search on a non-empty store raises busy_o and walks
// the ring store one entry per cycle through its single registered read port;
// each entry read is compared with the key once registered, and done_o pulses
// on the first match, with its 1-based position, or after the last entry on a
// miss. done_o is a single-cycle strobe that the receiver cannot hold off.
module deque_with_linear_search_top import dqls_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [2:0]              operation_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [CNT_W-1:0]        position_o,
  output logic [CNT_W-1:0]        occupancy_o
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] rd_data;
  res_t              res;

  dqls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .value_i     (value_i),
    .rd_data_i   (rd_data),
    .mem_req_o   (mem_req),
    .busy_o      (busy_o),
    .res_o       (res)
  );

  dqls_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

  assign done_o      = res.done;
  assign status_o    = res.status;
  assign position_o  = res.position;
  assign occupancy_o = res.occupancy;

endmodule
